@@ src/assert_macros.svh @@
// Assertion helpers used by the shaper datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define TBPS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define TBPS_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ src/tbps_pkg.sv @@
package tbps_pkg;

   // Default depth of the holding queue.
   localparam int QUEUE_DEPTH_DEF = 16;

   // Field widths.
   localparam int ID_W    = 16;
   localparam int TOKEN_W = 10;
   localparam int SVC_W   = 16;
   localparam int EVENT_W = 3;

   // Bucket capacity after reset.
   localparam logic [TOKEN_W-1:0] CAP_RESET = TOKEN_W'(10);

   // Event codes of a result item.
   typedef enum logic [EVENT_W-1:0] {
      EV_TOKEN_ADDED   = 3'd0,
      EV_TOKEN_DROPPED = 3'd1,
      EV_OVERSIZE      = 3'd2,
      EV_QUEUED        = 3'd3,
      EV_RELEASED      = 3'd4,
      EV_QUEUE_FULL    = 3'd5
   } event_type;

   // One packet held in the queue.
   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [TOKEN_W-1:0] need;
      logic [SVC_W-1:0]   svc;
   } entry_type;

   // One result item without its last flag.
   typedef struct packed {
      event_type          ev;
      logic [ID_W-1:0]    id;
      logic [SVC_W-1:0]   svc;
      logic [TOKEN_W-1:0] level;
   } result_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;
      logic tick;
      logic arrive;
      logic release_pkt;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_tick;
      logic can_release;
   } status_type;

endpackage

@@ src/token_bucket_packet_shaper.sv @@
// Token-bucket packet shaper with a FIFO holding queue.
// Request channel: an item is taken at a rising edge with start high and busy
// low. req_func 0 is a token tick, 1 is a packet arrival carrying id, token
// need and service time.
// Result channel: each result is shown for one cycle with rsp_valid high; the
// receiver cannot stall it. rsp_last marks the final result of an item.
// An arrival gives one result, registered from the execute state, and keeps
// busy high for one cycle. A tick gives its token result plus one result per
// released packet, one per cycle, from the check state; busy is high in the
// execute and check states until no packet can be released. The release loop
// reads the queue head from a registered-read memory, one packet per cycle.
// Configuration: csr_bucket_capacity is written when csr_valid and csr_ready
// are high; csr_ready is high while the block is idle and start is low.
// Reset clears the bucket, the queue pointers and sets the capacity to 10.
module token_bucket_packet_shaper #(
   parameter int QUEUE_DEPTH = tbps_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_func,
   input  logic [tbps_pkg::ID_W-1:0]     req_packet_id,
   input  logic [tbps_pkg::TOKEN_W-1:0]  req_tokens_needed,
   input  logic [tbps_pkg::SVC_W-1:0]    req_service_ms,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tbps_pkg::TOKEN_W-1:0]  csr_bucket_capacity,
   output logic                          rsp_valid,
   output logic [tbps_pkg::EVENT_W-1:0]  rsp_event_res,
   output logic [tbps_pkg::ID_W-1:0]     rsp_out_packet_id,
   output logic [tbps_pkg::SVC_W-1:0]    rsp_out_service_ms,
   output logic [tbps_pkg::TOKEN_W-1:0]  rsp_bucket_level,
   output logic                          rsp_last
);
   import tbps_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Capacity writes are taken while no item is in work or being offered.
   assign csr_ready = ~busy & ~start;

   tbps_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   tbps_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_func           (req_func),
      .req_packet_id      (req_packet_id),
      .req_tokens_needed  (req_tokens_needed),
      .req_service_ms     (req_service_ms),
      .cap_we             (csr_valid & csr_ready),
      .cap_wdata          (csr_bucket_capacity),
      .rsp_valid          (rsp_valid),
      .rsp_event_res      (rsp_event_res),
      .rsp_out_packet_id  (rsp_out_packet_id),
      .rsp_out_service_ms (rsp_out_service_ms),
      .rsp_bucket_level   (rsp_bucket_level),
      .rsp_last           (rsp_last)
   );

endmodule

@@ src/tbps_ctrl.sv @@
module tbps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  tbps_pkg::status_type status,
   output tbps_pkg::cmd_type    cmd,
   output logic                 busy
);
   import tbps_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_CHECK
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands for the datapath.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.is_tick) begin
               cmd.tick = 1'b1;
               state_in = ST_CHECK;
            end else begin
               cmd.arrive = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_CHECK: begin
            if (status.can_release) begin
               cmd.release_pkt = 1'b1;
            end else begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

@@ src/tbps_dpath.sv @@
module tbps_dpath #(
   parameter int QUEUE_DEPTH = tbps_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tbps_pkg::cmd_type             cmd,
   output tbps_pkg::status_type          status,
   input  logic                          req_func,
   input  logic [tbps_pkg::ID_W-1:0]     req_packet_id,
   input  logic [tbps_pkg::TOKEN_W-1:0]  req_tokens_needed,
   input  logic [tbps_pkg::SVC_W-1:0]    req_service_ms,
   input  logic                          cap_we,
   input  logic [tbps_pkg::TOKEN_W-1:0]  cap_wdata,
   output logic                          rsp_valid,
   output logic [tbps_pkg::EVENT_W-1:0]  rsp_event_res,
   output logic [tbps_pkg::ID_W-1:0]     rsp_out_packet_id,
   output logic [tbps_pkg::SVC_W-1:0]    rsp_out_service_ms,
   output logic [tbps_pkg::TOKEN_W-1:0]  rsp_bucket_level,
   output logic                          rsp_last
);
   import tbps_pkg::*;
   `include "assert_macros.svh"

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   // Holding queue storage and its registered head read.
   entry_type mem [QUEUE_DEPTH];
   entry_type rd_ff;

   logic [TOKEN_W-1:0] cap_ff;
   logic [TOKEN_W-1:0] level_ff, level_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               func_ff;
   entry_type          req_ff;
   result_type         pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               wr_en;

   assign status.is_tick     = ~func_ff;
   assign status.can_release = (count_ff != '0) && (rd_ff.need <= level_ff);

   // Item handling: token update, releases, final result, arrivals.
   always_comb begin
      level_in     = level_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      pend_in      = pend_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = pend_ff;
      rsp_last_in  = 1'b0;
      wr_en        = 1'b0;
      if (cmd.tick) begin
         pend_in = '0;
         if (level_ff < cap_ff) begin
            level_in   = level_ff + TOKEN_W'(1);
            pend_in.ev = EV_TOKEN_ADDED;
         end else begin
            pend_in.ev = EV_TOKEN_DROPPED;
         end
         pend_in.level = level_in;
      end
      if (cmd.release_pkt) begin
         level_in      = level_ff - rd_ff.need;
         head_in       = (head_ff == PTR_LAST) ? '0 : head_ff + PTR_W'(1);
         count_in      = count_ff - CNT_W'(1);
         rsp_valid_in  = 1'b1;
         pend_in.ev    = EV_RELEASED;
         pend_in.id    = rd_ff.id;
         pend_in.svc   = rd_ff.svc;
         pend_in.level = level_in;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = 1'b1;
      end
      if (cmd.arrive) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = 1'b1;
         rsp_in.id    = req_ff.id;
         rsp_in.svc   = '0;
         rsp_in.level = level_ff;
         if (req_ff.need > cap_ff) begin
            rsp_in.ev = EV_OVERSIZE;
         end else if (count_ff == CNT_FULL) begin
            rsp_in.ev = EV_QUEUE_FULL;
         end else begin
            rsp_in.ev = EV_QUEUED;
            wr_en     = 1'b1;
            tail_in   = (tail_ff == PTR_LAST) ? '0 : tail_ff + PTR_W'(1);
            count_in  = count_ff + CNT_W'(1);
         end
      end
   end

   // Queue memory: write at the tail, read the next head with write-first forwarding.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= req_ff;
      end
      if (wr_en && (tail_ff == head_in)) begin
         rd_ff <= req_ff;
      end else begin
         rd_ff <= mem[head_in];
      end
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         level_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cap_we) begin
            cap_ff <= cap_wdata;
         end
         level_ff     <= level_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: latched item, pending result, output result.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff     <= req_func;
         req_ff.id   <= req_packet_id;
         req_ff.need <= req_tokens_needed;
         req_ff.svc  <= req_service_ms;
      end
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_res      = rsp_ff.ev;
   assign rsp_out_packet_id  = rsp_ff.id;
   assign rsp_out_service_ms = rsp_ff.svc;
   assign rsp_bucket_level   = rsp_ff.level;
   assign rsp_last           = rsp_last_ff;

   // A release needs a packet in the queue.
   `TBPS_NEVER(a_release_nonempty, clock, reset, cmd.release_pkt && (count_ff == '0), "release from empty queue")
   // A release takes exactly the head packet's need from the bucket.
   `TBPS_ASSERT(a_release_level, clock, reset, cmd.release_pkt |=> level_ff == $past(level_ff) - $past(rd_ff.need), "release level mismatch")
   // An arrival yields one final result in the next cycle.
   `TBPS_ASSERT(a_arrive_result, clock, reset, cmd.arrive |=> rsp_valid_ff && rsp_last_ff, "arrival result missing")

endmodule
